@@ rtl/lsg_pkg.sv @@
package lsg_pkg;

  // strip length default and frame limit
  localparam int unsigned DefLedCount = 32;
  localparam int unsigned MaxFrame    = 32;

  // update intervals in ms and the wave seeding step
  localparam logic [8:0] CycleMs  = 9'd15;
  localparam logic [8:0] WaveMs   = 9'd5;
  localparam logic [7:0] SeedStep = 8'd32;

  localparam logic [7:0] LevelMax = 8'd255;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE      = 3'd0;
  localparam logic [2:0] REG_MODE        = 3'd1;
  localparam logic [2:0] REG_SOLID_RED   = 3'd2;
  localparam logic [2:0] REG_SOLID_GREEN = 3'd3;
  localparam logic [2:0] REG_SOLID_BLUE  = 3'd4;
  localparam logic [2:0] REG_STEP_SPEED  = 3'd5;
  localparam logic [2:0] REG_BRIGHTNESS  = 3'd6;

  typedef enum logic [1:0] {
    MODE_SOLID  = 2'd0,
    MODE_CYCLE  = 2'd1,
    MODE_WAVE   = 2'd2,
    MODE_FADE   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic       enable;
    mode_e      mode;
    logic [7:0] speed;
  } cfg_t;

  function automatic logic [7:0] add_sat(logic [7:0] a, logic [7:0] s);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, s};
    return sum[8] ? 8'hFF : sum[7:0];
  endfunction

  function automatic logic [7:0] sub_sat(logic [7:0] a, logic [7:0] s);
    return (a < s) ? 8'h00 : (a - s);
  endfunction

  // one step around the color wheel, one test for each of its six sides, each test sees the previous result
  function automatic rgb_t wheel_step(rgb_t c, logic [7:0] s);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    rgb_t       res;
    r = c.r;
    g = c.g;
    b = c.b;
    if (r == 8'h00 && g == 8'h00 && b == 8'h00) r = 8'hFF;
    if (r == 8'hFF && b == 8'h00) g = add_sat(g, s);
    if (g == 8'hFF && b == 8'h00) r = sub_sat(r, s);
    if (r == 8'h00 && g == 8'hFF) b = add_sat(b, s);
    if (r == 8'h00 && b == 8'hFF) g = sub_sat(g, s);
    if (g == 8'h00 && b == 8'hFF) r = add_sat(r, s);
    if (r == 8'hFF && g == 8'h00) b = sub_sat(b, s);
    res.r = r;
    res.g = g;
    res.b = b;
    return res;
  endfunction

endpackage

@@ rtl/lsg_if.sv @@
interface lsg_tick_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed_ms;

  modport source (output valid, output elapsed_ms, input ready);
  modport sink (input valid, input elapsed_ms, output ready);
endinterface

interface lsg_pixel_if;
  logic       valid;
  logic       ready;
  logic [4:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] global_level;
  logic       frame_end;

  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output global_level, output frame_end, input ready);
  modport sink (input valid, input pixel_index, input red, input green,
                input blue, input global_level, input frame_end, output ready);
endinterface

@@ rtl/led_strip_effect_generator.sv @@
// led strip effect generator
// tick_i carries one beat per millisecond tick with the time elapsed since the
// previous tick; pixel_o carries one beat per pixel of an emitted frame, in
// pixel order, with frame_end on the last one. the config port takes one
// register write per cycle (enable, mode, solid color, step speed,
// brightness load); the user must write it only while the block is idle,
// as the block itself does not enforce this.
// a tick that does not make an effect update due is absorbed in the cycle it
// is accepted and gives no beats. a due tick makes the sequencer walk the
// whole pixel memory: each pixel is read, recolored and written back, and the
// first min(32, LedCount) of them go out. each pixel passes through read,
// modify and write, send and handshake, and the next tick is taken once the
// last pixel is written back and any output is handed over. the sequencer
// works on one pixel at a time and starts none before the last is through.
// when pixel_o stalls the sequencer holds the pixel in the output register
// and waits; tick_i is not ready until the frame is done.
// reset puts the config registers at their defaults, the strip level at 255
// and the store at black: a flag marks the store as unwritten so reads come
// back black until the first update rewrites every pixel; no clearing pass is run.
module led_strip_effect_generator #(
  parameter int unsigned LedCount = lsg_pkg::DefLedCount
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsg_tick_if.sink            tick_i,
  lsg_pixel_if.source         pixel_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_wdata_i
);

  localparam int unsigned AddrW    = (LedCount > 1) ? $clog2(LedCount) : 1;
  localparam int unsigned FrameLen = (LedCount > lsg_pkg::MaxFrame) ?
                                     lsg_pkg::MaxFrame : LedCount;

  // one-hot sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_MODIFY = 4'b0100,
    ST_SEND   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  lsg_pkg::cfg_t cfg_q;
  lsg_pkg::rgb_t solid_q;
  logic          level_we;

  // effect state
  logic          seeded_q, seeded_d;
  logic          store_valid_q, store_valid_d;
  lsg_pkg::rgb_t seed_q, seed_d;
  lsg_pkg::rgb_t fill_q, fill_d;
  logic [AddrW-1:0] idx_q, idx_d;

  // output register
  logic          out_valid_q, out_valid_d;
  lsg_pkg::rgb_t out_px_q, out_px_d;
  logic [4:0]    out_idx_q, out_idx_d;
  logic [7:0]    out_level_q, out_level_d;
  logic          out_last_q, out_last_d;

  logic          tick_fire;
  logic          upd_due;
  logic [7:0]    level;

  lsg_pkg::rgb_t rd_px, src_px, wheel_in, wheel_out, new_px;
  logic [23:0]   rd_data;
  logic          ram_re, ram_we;

  logic          is_last_px;
  logic          in_frame;

  assign tick_i.ready = (state_q == ST_IDLE);
  assign tick_fire    = tick_i.valid && tick_i.ready;
  assign level_we     = cfg_we_i && cfg_index_i == lsg_pkg::REG_BRIGHTNESS;

  // tick timing and the fade level
  lsg_tick u_tick (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .fire_i        (tick_fire),
    .elapsed_ms_i  (tick_i.elapsed_ms),
    .level_we_i    (level_we),
    .level_wdata_i (cfg_wdata_i),
    .due_o         (upd_due),
    .level_o       (level)
  );

  // pixel store, read in the read state, written back in the modify state
  lsg_ram #(
    .Width (24),
    .Depth (LedCount)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (new_px),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign rd_px  = rd_data;
  // an unwritten store reads black
  assign src_px = store_valid_q ? rd_px : '0;

  assign is_last_px = (idx_q == AddrW'(LedCount - 1));
  assign in_frame   = ({1'b0, idx_q} < (AddrW + 1)'(FrameLen));

  // wheel input: rainbow cycle starts from black until seeded, wave from the seed walk
  always_comb begin
    if (cfg_q.mode == lsg_pkg::MODE_CYCLE) begin
      wheel_in = seeded_q ? src_px : '0;
    end else begin
      wheel_in = seeded_q ? src_px : seed_q;
    end
  end

  assign wheel_out = lsg_pkg::wheel_step(wheel_in, cfg_q.speed);

  // new color of the current pixel
  always_comb begin
    new_px = '0;
    if (cfg_q.enable) begin
      unique case (cfg_q.mode)
        lsg_pkg::MODE_SOLID: new_px = solid_q;
        lsg_pkg::MODE_FADE:  new_px = solid_q;
        lsg_pkg::MODE_CYCLE: new_px = (idx_q == '0) ? wheel_out : fill_q;
        lsg_pkg::MODE_WAVE:  new_px = wheel_out;
        default:             new_px = solid_q;
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable <= 1'b1;
      cfg_q.mode   <= lsg_pkg::MODE_SOLID;
      cfg_q.speed  <= 8'd8;
      solid_q      <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lsg_pkg::REG_ENABLE:      cfg_q.enable <= cfg_wdata_i[0];
        lsg_pkg::REG_MODE:        cfg_q.mode   <= lsg_pkg::mode_e'(cfg_wdata_i[1:0]);
        lsg_pkg::REG_SOLID_RED:   solid_q.r    <= cfg_wdata_i;
        lsg_pkg::REG_SOLID_GREEN: solid_q.g    <= cfg_wdata_i;
        lsg_pkg::REG_SOLID_BLUE:  solid_q.b    <= cfg_wdata_i;
        lsg_pkg::REG_STEP_SPEED:  cfg_q.speed  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    seeded_d      = seeded_q;
    store_valid_d = store_valid_q;
    seed_d        = seed_q;
    fill_d        = fill_q;
    out_valid_d   = out_valid_q;
    out_px_d      = out_px_q;
    out_idx_d     = out_idx_q;
    out_level_d   = out_level_q;
    out_last_d    = out_last_q;
    ram_re        = 1'b0;
    ram_we        = 1'b0;

    if (pixel_o.valid && pixel_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_we_i && (cfg_index_i == lsg_pkg::REG_ENABLE ||
                         cfg_index_i == lsg_pkg::REG_MODE)) begin
          seeded_d = 1'b0;
        end
        if (upd_due) begin
          idx_d   = '0;
          seed_d  = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
        // wave seeding walks one wheel step of 32 per pixel
        if (!seeded_q) begin
          seed_d = lsg_pkg::wheel_step(seed_q, lsg_pkg::SeedStep);
        end
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        ram_we = 1'b1;
        if (idx_q == '0) begin
          fill_d = wheel_out;
        end
        if (in_frame) begin
          out_valid_d = 1'b1;
          out_px_d    = new_px;
          out_idx_d   = 5'(idx_q);
          out_level_d = level;
          out_last_d  = ({1'b0, idx_q} == (AddrW + 1)'(FrameLen - 1));
        end
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (!out_valid_q) begin
          if (is_last_px) begin
            store_valid_d = 1'b1;
            if (cfg_q.enable && (cfg_q.mode == lsg_pkg::MODE_CYCLE ||
                                 cfg_q.mode == lsg_pkg::MODE_WAVE)) begin
              seeded_d = 1'b1;
            end
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      seeded_q      <= 1'b0;
      store_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      seeded_q      <= seeded_d;
      store_valid_q <= store_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    seed_q      <= seed_d;
    fill_q      <= fill_d;
    out_px_q    <= out_px_d;
    out_idx_q   <= out_idx_d;
    out_level_q <= out_level_d;
    out_last_q  <= out_last_d;
  end

  assign pixel_o.valid        = out_valid_q;
  assign pixel_o.pixel_index  = out_idx_q;
  assign pixel_o.red          = out_px_q.r;
  assign pixel_o.green        = out_px_q.g;
  assign pixel_o.blue         = out_px_q.b;
  assign pixel_o.global_level = out_level_q;
  assign pixel_o.frame_end    = out_last_q;

endmodule

@@ rtl/lsg_ram.sv @@
module lsg_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lsg_tick.sv @@
module lsg_tick (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsg_pkg::cfg_t       cfg_i,
  input  logic                fire_i,
  input  logic [7:0]          elapsed_ms_i,
  input  logic                level_we_i,
  input  logic [7:0]          level_wdata_i,
  output logic                due_o,
  output logic [7:0]          level_o
);

  logic [15:0] ms_q, ms_d;
  logic [7:0]  level_q, level_d;
  logic        rising_q, rising_d;
  logic [16:0] sum;
  logic [15:0] sat;
  logic [8:0]  interval;
  logic        due;

  assign sum = {1'b0, ms_q} + {9'd0, elapsed_ms_i};
  assign sat = sum[16] ? 16'hFFFF : sum[15:0];

  always_comb begin
    interval = 9'd0;
    if (cfg_i.enable) begin
      unique case (cfg_i.mode)
        lsg_pkg::MODE_CYCLE: interval = lsg_pkg::CycleMs;
        lsg_pkg::MODE_WAVE:  interval = lsg_pkg::WaveMs;
        lsg_pkg::MODE_FADE:  interval = {cfg_i.speed, 1'b0};
        default:             interval = 9'd0;
      endcase
    end
  end

  assign due = sat >= {7'd0, interval};

  always_comb begin
    ms_d     = ms_q;
    level_d  = level_q;
    rising_d = rising_q;
    if (level_we_i) begin
      level_d = level_wdata_i;
    end
    if (fire_i) begin
      ms_d = due ? 16'd0 : sat;
      if (due && cfg_i.enable && cfg_i.mode == lsg_pkg::MODE_FADE) begin
        if (level_q == lsg_pkg::LevelMax) begin
          rising_d = 1'b0;
        end else if (level_q == 8'd0) begin
          rising_d = 1'b1;
        end
        level_d = rising_d ? level_q + 8'd1 : level_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q     <= 16'd0;
      level_q  <= lsg_pkg::LevelMax;
      rising_q <= 1'b1;
    end else begin
      ms_q     <= ms_d;
      level_q  <= level_d;
      rising_q <= rising_d;
    end
  end

  assign due_o   = fire_i && due;
  assign level_o = level_q;

endmodule
